// ===== sv/whpwl_pkg.sv =====
`default_nettype none
package whpwl_pkg;

  localparam int unsigned CoordW = 35;
  localparam int unsigned SpanW  = 34;
  localparam int unsigned WgtW   = 16;
  localparam int unsigned CostW  = 50;
  localparam int unsigned TotW   = 63;

  localparam logic signed [CoordW-1:0] CoordTop    = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordBottom = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [TotW-1:0]          TotalMax    = {TotW{1'b1}};

  typedef struct packed {
    logic        first;
    logic        has_ext;
    logic [31:0] ext_lo;
    logic [31:0] ext_hi;
    logic [15:0] weight;
    logic [31:0] pos;
    logic [31:0] off_lo;
    logic [31:0] off_hi;
    logic [30:0] width;
    logic        flip;
    logic        last;
    logic        batch;
  } raw_t;

  typedef struct packed {
    logic              first;
    logic              has_ext;
    logic [CoordW-1:0] ext_lo;
    logic [CoordW-1:0] ext_hi;
    logic [WgtW-1:0]   weight;
    logic [CoordW-1:0] lo;
    logic [CoordW-1:0] hi;
    logic              last;
    logic              batch;
  } pin_t;

  typedef struct packed {
    logic [CoordW-1:0] span_min;
    logic [CoordW-1:0] span_max;
    logic [WgtW-1:0]   weight;
    logic              batch;
  } fin_t;

  typedef struct packed {
    logic [SpanW-1:0] span;
    logic [CostW-1:0] cost;
    logic             batch;
  } cost_t;

  function automatic logic [CoordW-1:0] sext32(input logic [31:0] v);
    sext32 = {{(CoordW-32){v[31]}}, v};
  endfunction

endpackage
`default_nettype wire

// ===== sv/weighted_hpwl_cost_evaluator_top.sv =====
// A net's result passes the raw, pin, fin, span, product and output registers.
// Throughput: one pin word per cycle; each stage holds one word and passes
// back-pressure upstream through its own ready, so no bubbles are forced.
// Reset: asynchronous, active low; clears all valid flags, the running total
// and the held weight, and returns the net interval to empty.
`default_nettype none
module weighted_hpwl_cost_evaluator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ext_min[31:0] ext_max[63:32] weight[79:64] cell_pos[111:80]
  // off_low[143:112] off_high[175:144] cell_width[206:176] pad[207]
  input  logic [207:0] s_axis_tdata,
  // net_first[0] has_external[1] flipped[2] batch_last[3]
  input  logic [3:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // net_span[33:0] net_cost[96:34] total_cost[159:97]
  output logic [159:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  import whpwl_pkg::*;

  raw_t             raw;
  logic             pin_valid;
  logic             pin_ready;
  pin_t             pin;
  logic             fin_valid;
  logic             fin_ready;
  fin_t             fin;
  logic             cost_valid;
  logic             cost_ready;
  cost_t            cost;
  logic [SpanW-1:0] span;
  logic [TotW-1:0]  net_cost;
  logic [TotW-1:0]  total;

  always_comb begin
    raw.first   = s_axis_tuser[0];
    raw.has_ext = s_axis_tuser[1];
    raw.ext_lo  = s_axis_tdata[31:0];
    raw.ext_hi  = s_axis_tdata[63:32];
    raw.weight  = s_axis_tdata[79:64];
    raw.pos     = s_axis_tdata[111:80];
    raw.off_lo  = s_axis_tdata[143:112];
    raw.off_hi  = s_axis_tdata[175:144];
    raw.width   = s_axis_tdata[206:176];
    raw.flip    = s_axis_tuser[2];
    raw.last    = s_axis_tlast;
    raw.batch   = s_axis_tuser[3];
  end

  whpwl_pin_stage u_pin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_raw_i    (raw),
    .out_valid_o (pin_valid),
    .out_ready_i (pin_ready),
    .out_pin_o   (pin)
  );

  whpwl_bound u_bound (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pin_valid),
    .in_ready_o  (pin_ready),
    .in_pin_i    (pin),
    .out_valid_o (fin_valid),
    .out_ready_i (fin_ready),
    .out_fin_o   (fin)
  );

  whpwl_cost u_cost (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fin_valid),
    .in_ready_o  (fin_ready),
    .in_fin_i    (fin),
    .out_valid_o (cost_valid),
    .out_ready_i (cost_ready),
    .out_cost_o  (cost)
  );

  whpwl_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cost_valid),
    .in_ready_o  (cost_ready),
    .in_cost_i   (cost),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_span_o  (span),
    .out_cost_o  (net_cost),
    .out_total_o (total),
    .out_final_o (m_axis_tlast)
  );

  assign m_axis_tdata = {total, net_cost, span};

endmodule
`default_nettype wire

// ===== sv/whpwl_pin_stage.sv =====
`default_nettype none
module whpwl_pin_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  whpwl_pkg::raw_t in_raw_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output whpwl_pkg::pin_t out_pin_o
);
  import whpwl_pkg::*;

  logic              raw_valid_q;
  raw_t              raw_q;
  logic              raw_ready;
  logic              pin_valid_q;
  pin_t              pin_q;
  pin_t              pin_d;
  logic [CoordW-1:0] base;
  logic [CoordW-1:0] lo_off;
  logic [CoordW-1:0] hi_off;

  assign raw_ready  = !pin_valid_q || out_ready_i;
  assign in_ready_o = !raw_valid_q || raw_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      raw_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      raw_q <= in_raw_i;
    end
  end

  // pin interval, mirrored across the cell when flipped
  always_comb begin
    base   = sext32(raw_q.pos);
    lo_off = sext32(raw_q.off_lo);
    hi_off = sext32(raw_q.off_hi);
    if (raw_q.flip) begin
      base   = base + {{(CoordW-31){1'b0}}, raw_q.width};
      lo_off = -sext32(raw_q.off_hi);
      hi_off = -sext32(raw_q.off_lo);
    end
    pin_d.first   = raw_q.first;
    pin_d.has_ext = raw_q.has_ext;
    pin_d.ext_lo  = sext32(raw_q.ext_lo);
    pin_d.ext_hi  = sext32(raw_q.ext_hi);
    pin_d.weight  = raw_q.weight;
    pin_d.lo      = base + lo_off;
    pin_d.hi      = base + hi_off;
    pin_d.last    = raw_q.last;
    pin_d.batch   = raw_q.batch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_valid_q <= 1'b0;
    end else if (raw_ready) begin
      pin_valid_q <= raw_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_ready && raw_valid_q) begin
      pin_q <= pin_d;
    end
  end

  assign out_valid_o = pin_valid_q;
  assign out_pin_o   = pin_q;

endmodule
`default_nettype wire

// ===== sv/whpwl_bound.sv =====
`default_nettype none
module whpwl_bound (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  whpwl_pkg::pin_t in_pin_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output whpwl_pkg::fin_t out_fin_o
);
  import whpwl_pkg::*;

  logic [CoordW-1:0] min_q, min_d;
  logic [CoordW-1:0] max_q, max_d;
  logic [WgtW-1:0]   wgt_q, wgt_d;
  logic [CoordW-1:0] base_min;
  logic [CoordW-1:0] base_max;
  logic              fin_valid_q;
  fin_t              fin_q;
  logic              fire;

  assign in_ready_o = !fin_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    base_min = min_q;
    base_max = max_q;
    wgt_d    = wgt_q;
    if (in_pin_i.first) begin
      wgt_d    = in_pin_i.weight;
      base_min = in_pin_i.has_ext ? in_pin_i.ext_lo : CoordTop;
      base_max = in_pin_i.has_ext ? in_pin_i.ext_hi : CoordBottom;
    end
    min_d = ($signed(in_pin_i.lo) < $signed(base_min)) ? in_pin_i.lo : base_min;
    max_d = ($signed(in_pin_i.hi) > $signed(base_max)) ? in_pin_i.hi : base_max;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= CoordTop;
      max_q <= CoordBottom;
      wgt_q <= '0;
    end else if (fire) begin
      wgt_q <= wgt_d;
      if (in_pin_i.last) begin
        min_q <= CoordTop;
        max_q <= CoordBottom;
      end else begin
        min_q <= min_d;
        max_q <= max_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      fin_valid_q <= fire && in_pin_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_pin_i.last) begin
      fin_q.span_min <= min_d;
      fin_q.span_max <= max_d;
      fin_q.weight   <= wgt_d;
      fin_q.batch    <= in_pin_i.batch;
    end
  end

  assign out_valid_o = fin_valid_q;
  assign out_fin_o   = fin_q;

endmodule
`default_nettype wire

// ===== sv/whpwl_cost.sv =====
`default_nettype none
module whpwl_cost (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  whpwl_pkg::fin_t  in_fin_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output whpwl_pkg::cost_t out_cost_o
);
  import whpwl_pkg::*;

  logic              sp_valid_q;
  logic [SpanW-1:0]  sp_span_q;
  logic [WgtW-1:0]   sp_wgt_q;
  logic              sp_batch_q;
  logic              sp_ready;
  logic [CoordW-1:0] diff;
  logic [SpanW-1:0]  span_d;
  logic              mul_valid_q;
  cost_t             mul_q;

  assign sp_ready   = !mul_valid_q || out_ready_i;
  assign in_ready_o = !sp_valid_q || sp_ready;

  // negative spans read as zero
  always_comb begin
    diff   = in_fin_i.span_max - in_fin_i.span_min;
    span_d = '0;
    if ($signed(in_fin_i.span_max) > $signed(in_fin_i.span_min)) begin
      span_d = diff[SpanW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      sp_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sp_span_q  <= span_d;
      sp_wgt_q   <= in_fin_i.weight;
      sp_batch_q <= in_fin_i.batch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (sp_ready) begin
      mul_valid_q <= sp_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sp_ready && sp_valid_q) begin
      mul_q.span  <= sp_span_q;
      mul_q.cost  <= CostW'(sp_wgt_q) * CostW'(sp_span_q);
      mul_q.batch <= sp_batch_q;
    end
  end

  assign out_valid_o = mul_valid_q;
  assign out_cost_o  = mul_q;

endmodule
`default_nettype wire

// ===== sv/whpwl_accum.sv =====
`default_nettype none
module whpwl_accum (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  whpwl_pkg::cost_t           in_cost_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [whpwl_pkg::SpanW-1:0] out_span_o,
  output logic [whpwl_pkg::TotW-1:0]  out_cost_o,
  output logic [whpwl_pkg::TotW-1:0]  out_total_o,
  output logic                       out_final_o
);
  import whpwl_pkg::*;

  logic [TotW-1:0]  total_q, total_d;
  logic [TotW:0]    sum;
  logic             fire;
  logic             out_valid_q;
  logic [SpanW-1:0] span_q;
  logic [TotW-1:0]  cost_q;
  logic [TotW-1:0]  res_q;
  logic             final_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // saturating add
  always_comb begin
    sum     = {1'b0, total_q} + (TotW+1)'(in_cost_i.cost);
    total_d = sum[TotW] ? TotalMax : sum[TotW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (fire) begin
      total_q <= in_cost_i.batch ? '0 : total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      span_q  <= in_cost_i.span;
      cost_q  <= TotW'(in_cost_i.cost);
      res_q   <= total_d;
      final_q <= in_cost_i.batch;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_span_o  = span_q;
  assign out_cost_o  = cost_q;
  assign out_total_o = res_q;
  assign out_final_o = final_q;

endmodule
`default_nettype wire

// ===== bench/tb_weighted_hpwl_cost_evaluator_top.sv =====
module tb_weighted_hpwl_cost_evaluator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import whpwl_pkg::*;

  localparam logic [31:0] S32Min   = 32'h8000_0000;
  localparam logic [31:0] S32Max   = 32'h7fff_ffff;
  localparam logic [30:0] W31Max   = 31'h7fff_ffff;
  localparam int          WideNets = 24;
  localparam int          HoldCyc  = 300;

  typedef struct packed {
    logic               first;
    logic               has_ext;
    logic signed [31:0] ext_min;
    logic signed [31:0] ext_max;
    logic [15:0]        weight;
    logic signed [31:0] pos;
    logic signed [31:0] off_lo;
    logic signed [31:0] off_hi;
    logic [30:0]        width;
    logic               flip;
    logic               last;
    logic               batch;
  } pin_word_t;

  typedef struct packed {
    logic [33:0] span;
    logic [62:0] cost;
    logic [62:0] total;
    logic        fin;
  } net_res_t;

  typedef struct {
    pin_word_t pin;
    bit        typed;
    net_res_t  want;
  } pin_row_t;

  logic         clk_i;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata  = '0;
  logic [3:0]   s_axis_tuser  = '0;
  logic         s_axis_tlast  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic         m_axis_tlast;

  weighted_hpwl_cost_evaluator_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // directed rows: pin fields, then whether the result is typed in, then the result
  pin_row_t pin_table [16] = '{
    '{'{0, 1, 123, 456, 999, 0, 0, 10, 0, 0, 1, 0}, 1, '{10, 0, 0, 0}},
    '{'{1, 0, 0, 0, 1, 0, 0, 10, 0, 0, 1, 0}, 1, '{10, 10, 10, 0}},
    '{'{1, 0, 0, 0, 3, 100, 2, 5, 20, 1, 1, 1}, 1, '{3, 9, 19, 1}},
    '{'{1, 0, 0, 0, 5, 0, 10, 0, 0, 0, 1, 0}, 1, '{0, 0, 0, 0}},
    '{'{1, 1, 100, 50, 7, 60, 0, 0, 0, 0, 1, 0}, 1, '{0, 0, 0, 0}},
    '{'{1, 1, -50, 50, 2, 10, -3, 4, 8, 0, 0, 0}, 0, '0},
    '{'{0, 1, -9999, 9999, 777, -100, 0, 5, 30, 1, 0, 1}, 0, '0},
    '{'{0, 0, 0, 0, 0, 200, -1, 1, 0, 0, 1, 0}, 0, '0},
    '{'{0, 0, 0, 0, 0, 0, -5, 5, 0, 0, 1, 0}, 0, '0},
    '{'{1, 1, S32Min, S32Max, 65535, S32Min, S32Min, S32Max, W31Max, 0, 0, 0}, 0, '0},
    '{'{0, 0, 0, 0, 0, S32Max, S32Min, S32Max, W31Max, 1, 1, 1}, 0, '0},
    '{'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0}, 1, '{0, 0, 0, 0}},
    '{'{1, 1, S32Min, S32Max, 0, 0, 0, 0, 0, 0, 1, 0}, 1, '{34'hffff_ffff, 0, 0, 0}},
    '{'{1, 0, 0, 0, 65535, -10, -20, 20, 0, 1, 1, 0}, 1, '{40, 2621400, 2621400, 0}},
    '{'{1, 0, 0, 0, 1, S32Min, S32Min, S32Min, W31Max, 1, 1, 1}, 1, '{0, 0, 2621400, 1}},
    '{'{1, 1, S32Max, S32Max, 65535, S32Min, S32Min, S32Min, 0, 0, 1, 1}, 0, '0}
  };

  logic signed [CoordW-1:0] lo_bound  = CoordTop;
  logic signed [CoordW-1:0] hi_bound  = CoordBottom;
  logic [WgtW-1:0]          net_wgt   = '0;
  logic [TotW-1:0]          cost_sum  = '0;

  net_res_t pending_nets [$];
  bit       tx_idle     = 1'b0;
  bit       rx_idle     = 1'b0;
  bit       rx_hold_req = 1'b0;
  int       pins_taken  = 0;
  int       nets_seen   = 0;
  int       nets_sat    = 0;
  int       bad_nets    = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d net results outstanding", pending_nets.size());
    $display("Regression FAIL");
    $finish;
  end

  // widens the net interval by one pin; returns 1 with the net result on its last pin
  function automatic bit fold_pin(input pin_word_t p, output net_res_t r);
    logic signed [CoordW-1:0] pos_w;
    logic signed [CoordW-1:0] wid_w;
    logic signed [CoordW-1:0] olo;
    logic signed [CoordW-1:0] ohi;
    logic signed [CoordW-1:0] lo;
    logic signed [CoordW-1:0] hi;
    logic [SpanW-1:0]         span;
    logic [TotW-1:0]          cost;
    r = '0;
    if (p.first) begin
      net_wgt = p.weight;
      if (p.has_ext) begin
        lo_bound = CoordW'(p.ext_min);
        hi_bound = CoordW'(p.ext_max);
      end else begin
        lo_bound = CoordTop;
        hi_bound = CoordBottom;
      end
    end
    pos_w = CoordW'(p.pos);
    wid_w = CoordW'({1'b0, p.width});
    olo   = CoordW'(p.off_lo);
    ohi   = CoordW'(p.off_hi);
    if (p.flip) begin
      lo = pos_w + wid_w - ohi;
      hi = pos_w + wid_w - olo;
    end else begin
      lo = pos_w + olo;
      hi = pos_w + ohi;
    end
    if (lo < lo_bound) lo_bound = lo;
    if (hi > hi_bound) hi_bound = hi;
    if (!p.last) return 1'b0;
    span = '0;
    if (hi_bound > lo_bound) span = SpanW'(hi_bound - lo_bound);
    cost = TotW'(net_wgt) * TotW'(span);
    if (cost > TotalMax - cost_sum) cost_sum = TotalMax;
    else cost_sum = cost_sum + cost;
    r.span  = span;
    r.cost  = cost;
    r.total = cost_sum;
    r.fin   = p.batch;
    if (p.batch) cost_sum = '0;
    lo_bound = CoordTop;
    hi_bound = CoordBottom;
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0:       return S32Min;
      1:       return S32Max;
      2:       return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic pin_word_t rand_pin();
    pin_word_t p;
    p.first   = 1'($urandom_range(0, 1));
    p.has_ext = 1'($urandom_range(0, 1));
    p.ext_min = pick32();
    p.ext_max = pick32();
    case ($urandom_range(0, 3))
      0:       p.weight = 16'hffff;
      1:       p.weight = 16'($urandom_range(0, 3));
      default: p.weight = 16'($urandom);
    endcase
    p.pos     = pick32();
    p.off_lo  = pick32();
    p.off_hi  = pick32();
    case ($urandom_range(0, 3))
      0:       p.width = W31Max;
      1:       p.width = 31'($urandom_range(0, 64));
      default: p.width = 31'($urandom);
    endcase
    p.flip    = 1'($urandom_range(0, 1));
    p.last    = 1'($urandom_range(0, 1));
    p.batch   = 1'($urandom_range(0, 1));
    return p;
  endfunction

  task automatic drive_pin(input pin_word_t p, input bit typed = 1'b0,
                           input net_res_t want = '0);
    net_res_t r;
    int       gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, p.width, p.off_hi, p.off_lo, p.pos, p.weight,
                      p.ext_max, p.ext_min};
    s_axis_tuser  <= {p.batch, p.flip, p.has_ext, p.first};
    s_axis_tlast  <= p.last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (fold_pin(p, r)) pending_nets.insert(pending_nets.size(), typed ? want : r);
    pins_taken++;
  endtask

  task automatic drain_nets();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_nets.size() != 0);
  endtask

  initial begin : rx_side
    int stall;
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCyc) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready) && !rx_hold_req);
    end
  end

  always @(posedge clk_i) begin : net_check
    net_res_t got;
    net_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.span  = m_axis_tdata[33:0];
      got.cost  = m_axis_tdata[96:34];
      got.total = m_axis_tdata[159:97];
      got.fin   = m_axis_tlast;
      nets_seen++;
      if (got.total == TotalMax) nets_sat++;
      if (pending_nets.size() == 0) begin
        if (bad_nets < 10)
          $display("%0t: unexpected word span=%0d cost=%0d total=%0d fin=%0b",
                   $realtime, got.span, got.cost, got.total, got.fin);
        bad_nets++;
      end else begin
        want = pending_nets.pop_front();
        if (got.span !== want.span || got.cost !== want.cost ||
            got.total !== want.total || got.fin !== want.fin) begin
          if (bad_nets < 10)
            $display("%0t: net %0d span %0d/%0d cost %0d/%0d total %0d/%0d fin %0b/%0b",
                     $realtime, nets_seen, want.span, got.span, want.cost, got.cost,
                     want.total, got.total, want.fin, got.fin);
          bad_nets++;
        end
      end
    end
  end

  initial begin : stimulus
    pin_word_t p;
    int        len;
    int        n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    foreach (pin_table[i]) drive_pin(pin_table[i].pin, pin_table[i].typed, pin_table[i].want);
    drain_nets();

    // back-to-back single-pin nets of a wide span at full weight
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int k = 0; k < WideNets; k++) begin
      p = '{1, 1, S32Min, S32Min, 16'hffff, S32Max, S32Min, S32Max, W31Max, 1, 1, 0};
      p.batch = (k == WideNets - 1);
      drive_pin(p);
    end
    drain_nets();

    for (int seg = 0; seg < 10; seg++) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (seg == 4) begin
        tx_idle = 1'b0;
        rx_hold_req = 1'b1;
      end
      n = 0;
      while (n < 50) begin
        if ($urandom_range(0, 9) < 2) begin
          drive_pin(rand_pin());
          n++;
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
          for (int j = 0; j < len; j++) begin
            p = rand_pin();
            p.first = (j == 0);
            p.last  = (j == len - 1);
            if (p.last) p.batch = ($urandom_range(0, 5) == 0);
            drive_pin(p);
          end
          n += len;
        end
      end
      if (seg % 3 == 2) drain_nets();
    end
    drain_nets();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d pin words and %0d net results, %0d of them at a saturated total",
             pins_taken, nets_seen, nets_sat);
    $display("Result mismatches or stray words: %0d", bad_nets);
    if (bad_nets == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/whpwl_pkg.sv
sv/whpwl_pin_stage.sv
sv/whpwl_bound.sv
sv/whpwl_cost.sv
sv/whpwl_accum.sv
sv/weighted_hpwl_cost_evaluator_top.sv
bench/tb_weighted_hpwl_cost_evaluator_top.sv
